/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define RLT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds through reset
`define RLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/rlt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rlt_pkg;

  localparam int UNIT_W    = 6;
  localparam int OWNER_W   = 3;
  localparam int OUNIT_W   = 8;
  localparam int TABLE_MAX = 2 ** UNIT_W;
  localparam int ADDR_W    = UNIT_W + 1;

  localparam int PIN_COUNT_DEF   = 64;
  localparam int TIMER_COUNT_DEF = 9;

  localparam logic FUNC_LOCK   = 1'b0;
  localparam logic FUNC_UNLOCK = 1'b1;

  localparam logic [1:0] CLASS_PIN   = 2'd0;
  localparam logic [1:0] CLASS_TIMER = 2'd1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HELD = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  localparam logic [OWNER_W-1:0] OWNER_FREE   = 3'd0;
  localparam logic [OWNER_W-1:0] OWNER_SYSTEM = 3'd1;

  typedef struct packed {
    logic               func;
    logic [1:0]         res_type;
    logic               any_unit;
    logic [UNIT_W-1:0]  unit;
    logic [OWNER_W-1:0] owner;
    logic [OUNIT_W-1:0] owner_inst;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [UNIT_W-1:0]  unit_out;
    logic [OWNER_W-1:0] holder_owner;
    logic [OUNIT_W-1:0] holder_unit;
  } rsp_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [OUNIT_W-1:0] ounit;
  } entry_t;

endpackage

`default_nettype wire

/* design/resource_lock_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// ownership table for pins and timers. a request beat either locks a named
// unit, locks the lowest free unit of its class, or unlocks a unit; every
// request beat gives exactly one response beat with status, unit and the
// holder now in that entry. owner records sit in one synchronous memory
// (pins in the lower half, timers in the upper half, addressed by class and
// unit); a flip-flop free bitmap per class, cleared by reset at once, feeds
// the priority encoder for any-free locks and tells free from held without
// a memory read. timer 0 belongs to the system after reset until it is
// first written. each request runs through the idle and execute states:
// in idle it is decoded against the free bitmap and issues the memory
// read; execute takes the read data, writes the entry back and loads the
// response register. req_stall is high in execute, so a new request beat
// is taken only once the last one is through; execute waits while a
// previous response beat is still stalled in the output register. no clearing pass is needed after reset.
module resource_lock_table_core #(
  parameter int PIN_COUNT   = rlt_pkg::PIN_COUNT_DEF,
  parameter int TIMER_COUNT = rlt_pkg::TIMER_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire rlt_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output rlt_pkg::rsp_t      rsp
);

  localparam int TMAX  = rlt_pkg::TABLE_MAX;
  localparam int UW    = rlt_pkg::UNIT_W;
  localparam int AW    = rlt_pkg::ADDR_W;
  localparam int DEPTH = 2 ** AW;

  // unit limits, one bit wider than a unit so the full table size fits
  localparam logic [UW:0] PIN_LIMIT   = (UW + 1)'(PIN_COUNT);
  localparam logic [UW:0] TIMER_LIMIT = (UW + 1)'(TIMER_COUNT);

  // bitmap bits that exist for each class
  localparam logic [TMAX-1:0] PIN_MASK   = {TMAX{1'b1}} >> (TMAX - PIN_COUNT);
  localparam logic [TMAX-1:0] TIMER_MASK = {TMAX{1'b1}} >> (TMAX - TIMER_COUNT);

  // sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  // what the execute cycle does, decided at accept
  localparam logic [2:0] K_BAD    = 3'd0;
  localparam logic [2:0] K_NONE   = 3'd1;
  localparam logic [2:0] K_UNLOCK = 3'd2;
  localparam logic [2:0] K_TAKE   = 3'd3;
  localparam logic [2:0] K_CHECK  = 3'd4;

  logic state;
  logic state_next;

  // owner records; entry contents only matter while the entry is held
  rlt_pkg::entry_t mem [DEPTH];
  rlt_pkg::entry_t rd_data;

  // free bitmaps, one bit per unit, bits past the class count stay zero
  logic [TMAX-1:0] pin_free;
  logic [TMAX-1:0] timer_free;

  // timer 0 still holds its reset owner (system) and was never written
  logic t0_sys;

  // request registered at accept
  logic [2:0]                   op_kind;
  logic                         op_cls;
  logic [UW-1:0]                op_unit;
  logic [rlt_pkg::OWNER_W-1:0]  op_owner;
  logic [rlt_pkg::OUNIT_W-1:0]  op_ounit;

  // accept side decode
  logic            accept;
  logic            cls;
  logic            class_ok;
  logic            unit_ok;
  logic [TMAX-1:0] free_vec;
  logic            enc_found;
  logic [UW-1:0]   enc_idx;
  logic [2:0]      kind;
  logic [UW-1:0]   sel_unit;

  // execute side
  logic            proceed;
  logic            wr_en;
  rlt_pkg::entry_t wr_data;
  rlt_pkg::entry_t held;
  rlt_pkg::rsp_t   rsp_next;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state == S_EXEC);
  assign proceed   = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  assign cls      = req.res_type[0];
  assign class_ok = req.res_type inside {rlt_pkg::CLASS_PIN, rlt_pkg::CLASS_TIMER};
  assign unit_ok  = cls ? ({1'b0, req.unit} < TIMER_LIMIT) : ({1'b0, req.unit} < PIN_LIMIT);
  assign free_vec = cls ? timer_free : pin_free;

  // lowest free unit of the class
  always_comb begin
    enc_found = 1'b0;
    enc_idx   = '0;
    for (int i = TMAX - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        enc_found = 1'b1;
        enc_idx   = UW'(i);
      end
    end
  end

  always_comb begin
    kind     = K_BAD;
    sel_unit = req.unit;
    if (!class_ok) begin
      kind = K_BAD;
    end else if (req.func == rlt_pkg::FUNC_UNLOCK) begin
      kind = unit_ok ? K_UNLOCK : K_BAD;
    end else if (req.owner == rlt_pkg::OWNER_FREE) begin
      kind = K_BAD;
    end else if (req.any_unit) begin
      kind     = enc_found ? K_TAKE : K_NONE;
      sel_unit = enc_idx;
    end else if (!unit_ok) begin
      kind = K_BAD;
    end else if (free_vec[req.unit]) begin
      kind = K_TAKE;
    end else begin
      kind = K_CHECK;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (proceed) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind  <= kind;
      op_cls   <= cls;
      op_unit  <= sel_unit;
      op_owner <= req.owner;
      op_ounit <= req.owner_inst;
    end
  end

  // memory read at accept, write back in the execute cycle; one item at a
  // time, so a write always lands before the next read
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[{cls, sel_unit}];
    end
    if (wr_en) begin
      mem[{op_cls, op_unit}] <= wr_data;
    end
  end

  always_comb begin
    wr_en   = proceed && ((op_kind == K_UNLOCK) || (op_kind == K_TAKE));
    wr_data = (op_kind == K_TAKE) ? rlt_pkg::entry_t'{owner: op_owner, ounit: op_ounit}
                                  : rlt_pkg::entry_t'{owner: rlt_pkg::OWNER_FREE, ounit: '0};
  end

  // timer 0 reads as system-owned until its first write
  assign held = (t0_sys && op_cls && (op_unit == '0))
              ? rlt_pkg::entry_t'{owner: rlt_pkg::OWNER_SYSTEM, ounit: '0}
              : rd_data;

  always_comb begin
    rsp_next = '{status: rlt_pkg::ST_BAD, unit_out: op_unit, holder_owner: '0, holder_unit: '0};
    case (op_kind)
      K_BAD: begin
        rsp_next.status = rlt_pkg::ST_BAD;
      end
      K_NONE: begin
        rsp_next.status   = rlt_pkg::ST_NONE;
        rsp_next.unit_out = '0;
      end
      K_UNLOCK: begin
        rsp_next.status = rlt_pkg::ST_OK;
      end
      K_TAKE: begin
        rsp_next.status       = rlt_pkg::ST_OK;
        rsp_next.holder_owner = op_owner;
        rsp_next.holder_unit  = op_ounit;
      end
      K_CHECK: begin
        rsp_next.status       = ((held.owner == op_owner) && (held.ounit == op_ounit))
                              ? rlt_pkg::ST_OK : rlt_pkg::ST_HELD;
        rsp_next.holder_owner = held.owner;
        rsp_next.holder_unit  = held.ounit;
      end
      default: begin
        rsp_next.status = rlt_pkg::ST_BAD;
      end
    endcase
  end

  // bitmaps and the timer 0 mark follow every write
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_free   <= PIN_MASK;
      timer_free <= TIMER_MASK & ~TMAX'(1);
      t0_sys     <= 1'b1;
    end else if (wr_en) begin
      if (op_cls) begin
        timer_free[op_unit] <= (op_kind == K_UNLOCK);
        if (op_unit == '0) begin
          t0_sys <= 1'b0;
        end
      end else begin
        pin_free[op_unit] <= (op_kind == K_UNLOCK);
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (proceed) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

/* design/rlt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rlt_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire rlt_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire rlt_pkg::rsp_t rsp
);

  // stalled response beat holds
  `RLT_ASSERT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "response changed under stall")

  // one request in flight: the cycle after a request beat is stalled
  `RLT_ASSERT(a_one_at_a_time, clk, rst, req_valid && !req_stall |=> req_stall, "request taken while busy")

  // a fresh response only comes out of an execute cycle
  `RLT_ASSERT(a_rsp_from_exec, clk, rst, $rose(rsp_valid) |-> $past(req_stall), "response without request")

  // none-free and bad responses carry no holder
  `RLT_ASSERT(a_empty_holder, clk, rst, rsp_valid && ((rsp.status == rlt_pkg::ST_NONE) || (rsp.status == rlt_pkg::ST_BAD)) |-> (rsp.holder_owner == '0) && (rsp.holder_unit == '0), "holder on failed request")

  // reset leaves both sides empty and open
  `RLT_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !rsp_valid && !req_stall, "not idle after reset")

endmodule

bind resource_lock_table_core rlt_checker u_rlt_checker (.*);

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int PIN_N   = rlt_pkg::PIN_COUNT_DEF;
  localparam int TMR_N   = rlt_pkg::TIMER_COUNT_DEF;
  localparam int TBL_N   = rlt_pkg::TABLE_MAX;
  localparam int UW      = rlt_pkg::UNIT_W;
  localparam int OW      = rlt_pkg::OWNER_W;
  localparam int OUW     = rlt_pkg::OUNIT_W;
  localparam int N_ITEMS = 1550;

  logic clk;
  logic rst = 1'b1;

  // request side, driven by the driver block
  logic          req_valid = 1'b0;
  logic          req_stall;
  rlt_pkg::req_t req       = '0;

  // response side
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  rlt_pkg::rsp_t rsp;

  resource_lock_table_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // pending request beats, filled up front and drained by the driver
  rlt_pkg::req_t req_q[$];
  // responses the ownership book says must come back, oldest first
  rlt_pkg::rsp_t outcome_q[$];

  // shadow ownership book: [0] pins, [1] timers
  rlt_pkg::entry_t book[2][TBL_N];

  int err_cnt = 0;
  int rsp_cnt = 0;
  int status_hits[4];

  task automatic note_error(string msg);
    $display("tb_top: mismatch on response %0d: %s", rsp_cnt, msg);
    err_cnt++;
  endtask

  // applies one request to the shadow book and returns the response it gives
  function automatic rlt_pkg::rsp_t book_outcome(rlt_pkg::req_t r);
    rlt_pkg::rsp_t o;
    int   cls;
    int   cnt;
    int   i;
    o.status       = rlt_pkg::ST_BAD;
    o.unit_out     = r.unit;
    o.holder_owner = rlt_pkg::OWNER_FREE;
    o.holder_unit  = '0;
    // unknown class
    if (r.res_type != rlt_pkg::CLASS_PIN && r.res_type != rlt_pkg::CLASS_TIMER) return o;
    cls = (r.res_type == rlt_pkg::CLASS_TIMER) ? 1 : 0;
    cnt = cls ? TMR_N : PIN_N;
    if (r.func == rlt_pkg::FUNC_UNLOCK) begin
      // unlock ignores owner fields; out-of-range unit is rejected
      if (int'(r.unit) >= cnt) return o;
      book[cls][r.unit] = '0;
      o.status = rlt_pkg::ST_OK;
      return o;
    end
    // owner code zero means free, so a lock with it is rejected
    if (r.owner == rlt_pkg::OWNER_FREE) return o;
    if (r.any_unit) begin
      for (i = 0; i < cnt; i++) begin
        if (book[cls][i].owner == rlt_pkg::OWNER_FREE) begin
          book[cls][i].owner = r.owner;
          book[cls][i].ounit = r.owner_inst;
          o.status       = rlt_pkg::ST_OK;
          o.unit_out     = UW'(i);
          o.holder_owner = r.owner;
          o.holder_unit  = r.owner_inst;
          return o;
        end
      end
      // class is full: everything zero but the status
      o          = '0;
      o.status   = rlt_pkg::ST_NONE;
      return o;
    end
    if (int'(r.unit) >= cnt) return o;
    // free entry is taken, then a held one is granted only to its holder
    if (book[cls][r.unit].owner == rlt_pkg::OWNER_FREE) begin
      book[cls][r.unit].owner = r.owner;
      book[cls][r.unit].ounit = r.owner_inst;
    end
    o.holder_owner = book[cls][r.unit].owner;
    o.holder_unit  = book[cls][r.unit].ounit;
    o.status = (o.holder_owner == r.owner && o.holder_unit == r.owner_inst)
             ? rlt_pkg::ST_OK : rlt_pkg::ST_HELD;
    return o;
  endfunction

  task automatic push_req(logic f, logic [1:0] rt, logic a, int u, int o, int ou);
    rlt_pkg::req_t r;
    r.func       = f;
    r.res_type   = rt;
    r.any_unit   = a;
    r.unit       = UW'(u);
    r.owner      = OW'(o);
    r.owner_inst = OUW'(ou);
    req_q.push_back(r);
  endtask

  // owners and owner units drawn from a small pool half the time so that
  // relocks by the same holder and clashes between holders come up often
  function automatic int pick_owner();
    if ($urandom_range(0, 19) == 0) return rlt_pkg::OWNER_FREE;
    if ($urandom_range(0, 1) == 0) return $urandom_range(1, 3);
    return $urandom_range(1, 7);
  endfunction

  function automatic int pick_ounit();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2);
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // one loosely shaped request: mostly sane classes and units, some noise
  function automatic rlt_pkg::req_t rand_req();
    rlt_pkg::req_t r;
    int   k;
    k = $urandom_range(0, 99);
    r.res_type   = (k < 45) ? rlt_pkg::CLASS_PIN
                 : (k < 90) ? rlt_pkg::CLASS_TIMER : 2'($urandom_range(2, 3));
    r.func       = ($urandom_range(0, 99) < 35) ? rlt_pkg::FUNC_UNLOCK : rlt_pkg::FUNC_LOCK;
    r.any_unit   = ($urandom_range(0, 3) == 0);
    if (r.res_type == rlt_pkg::CLASS_TIMER && $urandom_range(0, 99) < 85)
      r.unit = UW'($urandom_range(0, TMR_N - 1));
    else
      r.unit = UW'($urandom_range(0, TBL_N - 1));
    r.owner      = OW'(pick_owner());
    r.owner_inst = OUW'(pick_ounit());
    return r;
  endfunction

  // fill a class with any-free locks one past its size, then free most of it
  task automatic fill_and_sweep(logic [1:0] rt, int cnt);
    int i;
    int o;
    bit down;
    for (i = 0; i <= cnt; i++) begin
      o = $urandom_range(1, 7);
      push_req(rlt_pkg::FUNC_LOCK, rt, 1'b1, $urandom_range(0, TBL_N - 1), o,
               $urandom_range(0, 255));
    end
    down = 1'($urandom_range(0, 1));
    for (i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 9) < 8)
        push_req(rlt_pkg::FUNC_UNLOCK, rt, 1'($urandom_range(0, 1)),
                 down ? cnt - 1 - i : i, $urandom_range(0, 7), $urandom_range(0, 255));
    end
  endtask

  // --------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------
  initial begin : stim
    int i;
    int k;
    int u;
    int o;
    int ou;
    int n_dir;
    for (i = 0; i < TBL_N; i++) begin
      book[0][i] = '0;
      book[1][i] = '0;
    end
    // timer 0 belongs to the system out of reset
    book[1][0].owner = rlt_pkg::OWNER_SYSTEM;

    // directed: system-held timer, relock by holder, clashes at the top pin
    push_req(rlt_pkg::FUNC_LOCK, rlt_pkg::CLASS_TIMER, 1'b0, 0, 2, 5);
    push_req(rlt_pkg::FUNC_LOCK, rlt_pkg::CLASS_TIMER, 1'b0, 0, rlt_pkg::OWNER_SYSTEM, 0);
    push_req(rlt_pkg::FUNC_LOCK, rlt_pkg::CLASS_PIN, 1'b0, 63, 7, 255);
    push_req(rlt_pkg::FUNC_LOCK, rlt_pkg::CLASS_PIN, 1'b0, 63, 7, 254);
    push_req(rlt_pkg::FUNC_LOCK, rlt_pkg::CLASS_PIN, 1'b0, 63, 6, 255);
    push_req(rlt_pkg::FUNC_LOCK, rlt_pkg::CLASS_PIN, 1'b0, 0, rlt_pkg::OWNER_SYSTEM, 0);
    // out-of-range units, bad classes, owner code zero
    push_req(rlt_pkg::FUNC_LOCK, rlt_pkg::CLASS_TIMER, 1'b0, TMR_N, 3, 1);
    push_req(rlt_pkg::FUNC_LOCK, rlt_pkg::CLASS_TIMER, 1'b0, 63, 3, 1);
    push_req(rlt_pkg::FUNC_UNLOCK, rlt_pkg::CLASS_TIMER, 1'b0, TMR_N, 3, 1);
    push_req(rlt_pkg::FUNC_LOCK, 2'd2, 1'b0, 5, 4, 9);
    push_req(rlt_pkg::FUNC_UNLOCK, 2'd3, 1'b1, 63, 7, 255);
    push_req(rlt_pkg::FUNC_LOCK, rlt_pkg::CLASS_PIN, 1'b0, 10, rlt_pkg::OWNER_FREE, 3);
    push_req(rlt_pkg::FUNC_LOCK, rlt_pkg::CLASS_PIN, 1'b1, 10, rlt_pkg::OWNER_FREE, 3);
    // any-free timers until none are left; unit field is junk on purpose
    for (i = 0; i < TMR_N; i++)
      push_req(rlt_pkg::FUNC_LOCK, rlt_pkg::CLASS_TIMER, 1'b1, 63 - i, 5, i);
    // free the system timer, then any-free must pick it
    push_req(rlt_pkg::FUNC_UNLOCK, rlt_pkg::CLASS_TIMER, 1'b0, 0, 2, 7);
    push_req(rlt_pkg::FUNC_LOCK, rlt_pkg::CLASS_TIMER, 1'b1, 33, 4, 200);
    // unlock ignores owner fields entirely
    push_req(rlt_pkg::FUNC_UNLOCK, rlt_pkg::CLASS_PIN, 1'b1, 63, rlt_pkg::OWNER_FREE, 0);
    n_dir = req_q.size();

    // random part: mostly well-formed lock/relock/unlock patterns,
    // occasional fills to reach the none-free status, plus noise
    while (req_q.size() < n_dir + N_ITEMS) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        req_q.push_back(rand_req());
      end else if (k < 72) begin
        // take a unit, relock as holder, clash, release
        k  = $urandom_range(0, 1);
        u  = k ? $urandom_range(0, TMR_N - 1) : $urandom_range(0, PIN_N - 1);
        o  = $urandom_range(1, 7);
        ou = $urandom_range(0, 255);
        push_req(rlt_pkg::FUNC_LOCK, k ? rlt_pkg::CLASS_TIMER : rlt_pkg::CLASS_PIN,
                 1'b0, u, o, ou);
        push_req(rlt_pkg::FUNC_LOCK, k ? rlt_pkg::CLASS_TIMER : rlt_pkg::CLASS_PIN,
                 1'b0, u, o, ou);
        push_req(rlt_pkg::FUNC_LOCK, k ? rlt_pkg::CLASS_TIMER : rlt_pkg::CLASS_PIN,
                 1'b0, u, o, ou ^ (1 << $urandom_range(0, 7)));
        push_req(rlt_pkg::FUNC_LOCK, k ? rlt_pkg::CLASS_TIMER : rlt_pkg::CLASS_PIN,
                 1'b0, u, (o % 7) + 1, ou);
        if ($urandom_range(0, 3) != 0)
          push_req(rlt_pkg::FUNC_UNLOCK, k ? rlt_pkg::CLASS_TIMER : rlt_pkg::CLASS_PIN,
                   1'b0, u, pick_owner(), ou);
      end else if (k < 84) begin
        fill_and_sweep(rlt_pkg::CLASS_TIMER, TMR_N);
      end else if (k < 86) begin
        fill_and_sweep(rlt_pkg::CLASS_PIN, PIN_N);
      end else begin
        // noise burst
        for (i = $urandom_range(5, 20); i > 0; i--) req_q.push_back(rand_req());
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // every beat accepted and every response back
    while (req_q.size() != 0 || req_valid || outcome_q.size() != 0) @(posedge clk);
    // then keep running to catch a stray response
    repeat (20) @(posedge clk);

    $display("run covered %0d request beats, directed and random, with bursty input and stalls",
             rsp_cnt);
    $display("responses: granted %0d, held by other %0d, none free %0d, bad request %0d",
             status_hits[rlt_pkg::ST_OK], status_hits[rlt_pkg::ST_HELD],
             status_hits[rlt_pkg::ST_NONE], status_hits[rlt_pkg::ST_BAD]);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // --------------------------------------------------------------------
  // driver: bursts of beats separated by random gaps
  // --------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    logic nv;
    logic take;
    if (rst) begin
      req_valid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      take = req_valid && !req_stall;
      // predict at the accepting edge so expectations stay in beat order
      if (take) outcome_q.push_back(book_outcome(req));
      // payload holds while stalled; only move on when the slot is empty
      if (!req_valid || take) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() != 0) begin
          req <= req_q.pop_front();
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // next burst; a third of the time back to back with no gap
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        req_valid <= nv;
      end
    end
  end

  // --------------------------------------------------------------------
  // response stall pattern: phases of no stall, random stall, long runs
  // --------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;
  int run_left   = 0;

  always @(posedge clk) begin
    logic ns;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: ns = 1'b0;
        1: ns = ($urandom_range(0, 2) == 0);
        default: begin
          if (run_left == 0) begin
            ns       = !rsp_stall;
            run_left = $urandom_range(1, 12);
          end else begin
            ns = rsp_stall;
            run_left--;
          end
        end
      endcase
      rsp_stall <= ns;
    end
  end

  // --------------------------------------------------------------------
  // monitor: every accepted response against the oldest expectation
  // --------------------------------------------------------------------
  always @(posedge clk) begin
    rlt_pkg::rsp_t want;
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      if (outcome_q.size() == 0) begin
        note_error($sformatf("unexpected beat %p", rsp));
      end else begin
        want = outcome_q.pop_front();
        if (rsp.status !== want.status)
          note_error($sformatf("status %0d, want %0d", rsp.status, want.status));
        if (rsp.unit_out !== want.unit_out)
          note_error($sformatf("unit_out %0d, want %0d", rsp.unit_out, want.unit_out));
        if (rsp.holder_owner !== want.holder_owner)
          note_error($sformatf("holder_owner %0d, want %0d", rsp.holder_owner,
                               want.holder_owner));
        if (rsp.holder_unit !== want.holder_unit)
          note_error($sformatf("holder_unit %0d, want %0d", rsp.holder_unit,
                               want.holder_unit));
        status_hits[want.status]++;
      end
      rsp_cnt++;
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #1000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
